### rtl/cluhn_pkg.sv
// Shared types and constants for the card number Luhn classifier.
// No dependencies; used by card_number_luhn_classifier.
package cluhn_pkg;

	localparam int unsigned CardWidth  = 57;
	localparam int unsigned NumDigits  = 18;
	localparam int unsigned BcdWidth   = NumDigits * 4;
	localparam int unsigned CountWidth = 5;
	localparam int unsigned StepWidth  = 6;

	typedef enum logic [1:0] {
		VERDICT_INVALID    = 2'd0,
		VERDICT_AMEX       = 2'd1,
		VERDICT_MASTERCARD = 2'd2,
		VERDICT_VISA       = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

### rtl/card_number_luhn_classifier.sv
// Top level of the card number Luhn classifier: binary to BCD, digit scan, brand decode.
// Depends on cluhn_pkg.
//
// Usage:
//   Input channel: in_valid/in_ready with card_number (57-bit unsigned binary).
//   Output channel: out_valid/out_ready with verdict, luhn_ok and digit_count.
//   A beat moves when valid and ready are both high at a rising edge of clk.
//
// Sequencing and throughput:
//   One item at a time. After acceptance the number runs through a shift-and-add-3
//   converter, one input bit per cycle, then a digit scan walks the 18 BCD digits
//   least significant first, one per cycle, then the FIN state decodes the brand
//   into the output register. The sequencer returns to idle with that load, so the
//   next item can be accepted while the result is still offered; the bit-serial
//   converter takes the longest part of each item.
//
// Stalls and reset:
//   The result waits in the output register while out_ready is low; a new item
//   is still accepted and converted meanwhile, and holds in the decode step until
//   the output register is free. arst_n clears the sequencer and out_valid.
module card_number_luhn_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [56:0] card_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic        luhn_ok,
	output logic [4:0]  digit_count
);

	cluhn_pkg::state_t state_q, state_d;

	// binary shift register feeding the BCD register one bit per cycle
	logic [cluhn_pkg::CardWidth-1:0]  bin_q;
	logic [cluhn_pkg::BcdWidth-1:0]   bcd_q;
	logic [cluhn_pkg::BcdWidth-1:0]   bcd_adj;
	logic [cluhn_pkg::StepWidth-1:0]  step_q;

	// digit scan accumulators
	logic [3:0]                        sum_q;     // running Luhn sum mod 10
	logic [cluhn_pkg::CountWidth-1:0] count_q;   // highest nonzero position + 1
	logic [3:0]                        hi_q;      // leading digit
	logic [3:0]                        lo_q;      // second digit
	logic [3:0]                        prev_q;    // digit scanned last cycle

	logic [3:0] digit;
	logic [4:0] dbl;
	logic [3:0] term;
	logic [4:0] sum_raw;
	logic [3:0] sum_next;

	logic                 out_valid_q;
	cluhn_pkg::verdict_t  verdict_q, verdict_d;
	logic                 luhn_ok_q;
	logic [4:0]           digit_count_q;

	logic conv_last;
	logic scan_last;
	logic fin_load;

	assign in_ready    = (state_q == cluhn_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign luhn_ok     = luhn_ok_q;
	assign digit_count = digit_count_q;

	assign conv_last = (step_q == cluhn_pkg::StepWidth'(cluhn_pkg::CardWidth - 1));
	assign scan_last = (step_q == cluhn_pkg::StepWidth'(cluhn_pkg::NumDigits - 1));
	assign fin_load  = (state_q == cluhn_pkg::ST_FIN) && (!out_valid_q || out_ready);

	// add-3 correction on every digit before the shift
	always_comb begin
		for (int i = 0; i < cluhn_pkg::NumDigits; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Luhn term of the current digit; odd positions from the right are doubled
	always_comb begin
		digit = bcd_q[3:0];
		dbl   = {digit, 1'b0};
		if (step_q[0]) begin
			term = (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
		end else begin
			term = digit;
		end
		sum_raw  = {1'b0, sum_q} + {1'b0, term};
		sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
	end

	// brand decode from the Luhn sum, the count and the leading two digits
	always_comb begin
		verdict_d = cluhn_pkg::VERDICT_INVALID;
		if (sum_q == 4'd0) begin
			if (count_q == cluhn_pkg::CountWidth'(15)) begin
				if (hi_q == 4'd3 && (lo_q == 4'd4 || lo_q == 4'd7)) begin
					verdict_d = cluhn_pkg::VERDICT_AMEX;
				end
			end else if (count_q == cluhn_pkg::CountWidth'(16)) begin
				if (hi_q == 4'd5 && lo_q >= 4'd1 && lo_q <= 4'd5) begin
					verdict_d = cluhn_pkg::VERDICT_MASTERCARD;
				end else if (hi_q == 4'd4) begin
					verdict_d = cluhn_pkg::VERDICT_VISA;
				end
			end else if (count_q == cluhn_pkg::CountWidth'(13)) begin
				if (hi_q == 4'd4) begin
					verdict_d = cluhn_pkg::VERDICT_VISA;
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cluhn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cluhn_pkg::ST_IDLE: begin
				if (in_valid) state_d = cluhn_pkg::ST_CONV;
			end
			cluhn_pkg::ST_CONV: begin
				if (conv_last) state_d = cluhn_pkg::ST_SCAN;
			end
			cluhn_pkg::ST_SCAN: begin
				if (scan_last) state_d = cluhn_pkg::ST_FIN;
			end
			cluhn_pkg::ST_FIN: begin
				if (fin_load) state_d = cluhn_pkg::ST_IDLE;
			end
			default: state_d = cluhn_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == cluhn_pkg::ST_IDLE ||
		             (state_q == cluhn_pkg::ST_CONV && conv_last)) begin
			step_q <= '0;
		end else if (state_q == cluhn_pkg::ST_CONV || state_q == cluhn_pkg::ST_SCAN) begin
			step_q <= step_q + 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == cluhn_pkg::ST_IDLE && in_valid) begin
			bin_q <= card_number;
			bcd_q <= '0;
		end else if (state_q == cluhn_pkg::ST_CONV) begin
			bin_q <= {bin_q[cluhn_pkg::CardWidth-2:0], 1'b0};
			bcd_q <= {bcd_adj[cluhn_pkg::BcdWidth-2:0], bin_q[cluhn_pkg::CardWidth-1]};
			if (conv_last) begin
				sum_q   <= '0;
				count_q <= '0;
				hi_q    <= '0;
				lo_q    <= '0;
				prev_q  <= '0;
			end
		end else if (state_q == cluhn_pkg::ST_SCAN) begin
			bcd_q  <= {4'd0, bcd_q[cluhn_pkg::BcdWidth-1:4]};
			sum_q  <= sum_next;
			prev_q <= digit;
			if (digit != 4'd0) begin
				count_q <= cluhn_pkg::CountWidth'(step_q) + 1'b1;
				hi_q    <= digit;
				lo_q    <= prev_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			verdict_q     <= verdict_d;
			luhn_ok_q     <= (sum_q == 4'd0);
			digit_count_q <= count_q;
		end
	end

`ifndef SYNTH
	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == cluhn_pkg::ST_CONV)
		else $error("accepted beat did not start conversion");

	a_brand_needs_luhn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict != cluhn_pkg::VERDICT_INVALID |-> luhn_ok)
		else $error("brand reported without passing checksum");

	a_amex_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == cluhn_pkg::VERDICT_AMEX |-> digit_count == 5'd15)
		else $error("amex with wrong digit count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cluhn_pkg::ST_SCAN |-> step_q < cluhn_pkg::StepWidth'(cluhn_pkg::NumDigits))
		else $error("digit scan ran past last digit");

	a_fin_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cluhn_pkg::ST_FIN && out_valid && !out_ready
		|=> state_q == cluhn_pkg::ST_FIN)
		else $error("decode overwrote a pending result");
`endif

endmodule
